@@ sv/sbbc_pkg.sv @@
// Shared constants and types for the segment/box border crossing block.
package sbbc_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic [3:0] EDGE_LEFT  = 4'b0001;
  localparam logic [3:0] EDGE_RIGHT = 4'b0010;
  localparam logic [3:0] EDGE_CEIL  = 4'b0100;
  localparam logic [3:0] EDGE_FLOOR = 4'b1000;

  typedef struct packed {
    logic       valid;
    logic       keep;
    logic [3:0] excl;
    logic       found;
    logic       vert;
    logic [3:0] mask;
  } sbbc_ctl_t;

endpackage

@@ sv/sbbc_front.sv @@
// Edge setup, range products and per-axis earliest edge selection (three stages).
module sbbc_front #(
  parameter int W = sbbc_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   in_start_x,
  input  logic signed [W-1:0]   in_start_y,
  input  logic signed [W-1:0]   in_target_x,
  input  logic signed [W-1:0]   in_target_y,
  input  logic signed [W-1:0]   in_box_left,
  input  logic signed [W-1:0]   in_box_top,
  input  logic [W-2:0]          in_box_width,
  input  logic [W-2:0]          in_box_height,
  input  logic                  in_box_is_inner,
  input  logic [3:0]            in_exclude_mask,
  input  logic                  in_keep_target,
  output sbbc_pkg::sbbc_ctl_t   f_ctl,
  output logic                  f_vhave,
  output logic [3:0]            f_vmask,
  output logic [W-1:0]          f_vn,
  output logic signed [2*W+2:0] f_valong,
  output logic signed [W:0]     f_vpos,
  output logic                  f_hhave,
  output logic [3:0]            f_hmask,
  output logic [W-1:0]          f_hn,
  output logic signed [2*W+2:0] f_halong,
  output logic signed [W:0]     f_hpos,
  output logic [W-1:0]          f_adx,
  output logic [W-1:0]          f_ady,
  output logic signed [W-1:0]   f_sx,
  output logic signed [W-1:0]   f_sy,
  output logic signed [W-1:0]   f_tx,
  output logic signed [W-1:0]   f_ty
);
  import sbbc_pkg::*;

  localparam int PW = 2 * W + 3;

  // stage 1
  logic signed [W:0]   sx, sy, tx, ty, l, t, r, b, dx, dy, adxw, adyw;
  logic signed [W+1:0] nl_raw, nr_raw, nt_raw, nb_raw, nl_f, nr_f, nt_f, nb_f;
  logic                sin, tin, react;
  logic [3:0]          excl;

  sbbc_ctl_t           ctl1_r, ctl1_nxt;
  logic [W-1:0]        adx1_r, ady1_r, nl1_r, nr1_r, nt1_r, nb1_r;
  logic [W-1:0]        adx1_nxt, ady1_nxt;
  logic [3:0]          ok1_r, ok1_nxt;
  logic signed [W+1:0] vlo1_r, vhi1_r, hlo1_r, hhi1_r;
  logic signed [W+1:0] vlo1_nxt, vhi1_nxt, hlo1_nxt, hhi1_nxt;
  logic signed [W:0]   dx1_r, dy1_r, l1_r, r1_r, t1_r, b1_r;
  logic signed [W-1:0] sx1_r, sy1_r, tx1_r, ty1_r;

  always_comb begin
    sx = {in_start_x[W-1], in_start_x};
    sy = {in_start_y[W-1], in_start_y};
    tx = {in_target_x[W-1], in_target_x};
    ty = {in_target_y[W-1], in_target_y};
    l  = {in_box_left[W-1], in_box_left};
    t  = {in_box_top[W-1], in_box_top};
    r  = l + $signed({2'b00, in_box_width});
    b  = t + $signed({2'b00, in_box_height});
    dx = tx - sx;
    dy = ty - sy;
    adxw = dx[W] ? -dx : dx;
    adyw = dy[W] ? -dy : dy;
    adx1_nxt = adxw[W-1:0];
    ady1_nxt = adyw[W-1:0];

    excl = in_exclude_mask;
    if (sy == t && ty == t) excl = excl | EDGE_CEIL;
    if (sy == b && ty == b) excl = excl | EDGE_FLOOR;
    if (sx == l && tx == l) excl = excl | EDGE_LEFT;
    if (sx == r && tx == r) excl = excl | EDGE_RIGHT;

    sin   = sx >= l && sx <= r && sy >= t && sy <= b;
    tin   = tx >= l && tx <= r && ty >= t && ty <= b;
    react = in_box_is_inner ? (sin && !tin) : (!sin && tin);

    nl_raw = {l[W], l} - {sx[W], sx};
    nr_raw = {r[W], r} - {sx[W], sx};
    nt_raw = {t[W], t} - {sy[W], sy};
    nb_raw = {b[W], b} - {sy[W], sy};
    nl_f = dx[W] ? -nl_raw : nl_raw;
    nr_f = dx[W] ? -nr_raw : nr_raw;
    nt_f = dy[W] ? -nt_raw : nt_raw;
    nb_f = dy[W] ? -nb_raw : nb_raw;
    ok1_nxt[0] = react && nl_f > 0 && nl_f <= $signed({2'b00, adx1_nxt});
    ok1_nxt[1] = react && nr_f > 0 && nr_f <= $signed({2'b00, adx1_nxt});
    ok1_nxt[2] = react && nt_f > 0 && nt_f <= $signed({2'b00, ady1_nxt});
    ok1_nxt[3] = react && nb_f > 0 && nb_f <= $signed({2'b00, ady1_nxt});

    vlo1_nxt = {t[W], t} - {sy[W], sy};
    vhi1_nxt = {b[W], b} - {sy[W], sy};
    hlo1_nxt = {l[W], l} - {sx[W], sx};
    hhi1_nxt = {r[W], r} - {sx[W], sx};

    ctl1_nxt       = '0;
    ctl1_nxt.valid = in_valid;
    ctl1_nxt.keep  = in_keep_target;
    ctl1_nxt.excl  = excl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
    end
    adx1_r <= adx1_nxt;  ady1_r <= ady1_nxt;
    ok1_r  <= ok1_nxt;
    nl1_r  <= nl_f[W-1:0];  nr1_r <= nr_f[W-1:0];
    nt1_r  <= nt_f[W-1:0];  nb1_r <= nb_f[W-1:0];
    vlo1_r <= vlo1_nxt;  vhi1_r <= vhi1_nxt;
    hlo1_r <= hlo1_nxt;  hhi1_r <= hhi1_nxt;
    dx1_r  <= dx;  dy1_r <= dy;
    l1_r   <= l;  r1_r <= r;  t1_r <= t;  b1_r <= b;
    sx1_r  <= in_start_x;  sy1_r <= in_start_y;
    tx1_r  <= in_target_x;  ty1_r <= in_target_y;
  end

  // stage 2: products
  sbbc_ctl_t            ctl2_r;
  logic signed [PW-1:0] pvlo2_r, pvhi2_r, phlo2_r, phhi2_r;
  logic signed [PW-1:0] al2_r, ar2_r, at2_r, ab2_r;
  logic [W-1:0]         adx2_r, ady2_r, nl2_r, nr2_r, nt2_r, nb2_r;
  logic [3:0]           ok2_r;
  logic signed [W:0]    l2_r, r2_r, t2_r, b2_r;
  logic signed [W-1:0]  sx2_r, sy2_r, tx2_r, ty2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
    pvlo2_r <= vlo1_r * $signed({1'b0, adx1_r});
    pvhi2_r <= vhi1_r * $signed({1'b0, adx1_r});
    phlo2_r <= hlo1_r * $signed({1'b0, ady1_r});
    phhi2_r <= hhi1_r * $signed({1'b0, ady1_r});
    al2_r   <= $signed({1'b0, nl1_r}) * dy1_r;
    ar2_r   <= $signed({1'b0, nr1_r}) * dy1_r;
    at2_r   <= $signed({1'b0, nt1_r}) * dx1_r;
    ab2_r   <= $signed({1'b0, nb1_r}) * dx1_r;
    adx2_r  <= adx1_r;  ady2_r <= ady1_r;
    nl2_r   <= nl1_r;  nr2_r <= nr1_r;  nt2_r <= nt1_r;  nb2_r <= nb1_r;
    ok2_r   <= ok1_r;
    l2_r    <= l1_r;  r2_r <= r1_r;  t2_r <= t1_r;  b2_r <= b1_r;
    sx2_r   <= sx1_r;  sy2_r <= sy1_r;  tx2_r <= tx1_r;  ty2_r <= ty1_r;
  end

  // stage 3: extent checks, earliest edge per axis
  logic                 okl, okr, okt, okb;
  logic                 vhave_nxt, hhave_nxt;
  logic [3:0]           vmask_nxt, hmask_nxt;
  logic [W-1:0]         vn_nxt, hn_nxt;
  logic signed [PW-1:0] valong_nxt, halong_nxt;
  logic signed [W:0]    vpos_nxt, hpos_nxt;

  always_comb begin
    okl = ok2_r[0] && pvlo2_r <= al2_r && al2_r <= pvhi2_r;
    okr = ok2_r[1] && pvlo2_r <= ar2_r && ar2_r <= pvhi2_r;
    okt = ok2_r[2] && phlo2_r <= at2_r && at2_r <= phhi2_r;
    okb = ok2_r[3] && phlo2_r <= ab2_r && ab2_r <= phhi2_r;

    vhave_nxt = okl || okr;
    if (okl && (!okr || nl2_r <= nr2_r)) begin
      vn_nxt = nl2_r;  valong_nxt = al2_r;  vpos_nxt = l2_r;
    end else begin
      vn_nxt = nr2_r;  valong_nxt = ar2_r;  vpos_nxt = r2_r;
    end
    vmask_nxt = ((okl && (!okr || nl2_r <= nr2_r)) ? EDGE_LEFT : 4'b0000) |
                ((okr && (!okl || nr2_r <= nl2_r)) ? EDGE_RIGHT : 4'b0000);

    hhave_nxt = okt || okb;
    if (okt && (!okb || nt2_r <= nb2_r)) begin
      hn_nxt = nt2_r;  halong_nxt = at2_r;  hpos_nxt = t2_r;
    end else begin
      hn_nxt = nb2_r;  halong_nxt = ab2_r;  hpos_nxt = b2_r;
    end
    hmask_nxt = ((okt && (!okb || nt2_r <= nb2_r)) ? EDGE_CEIL : 4'b0000) |
                ((okb && (!okt || nb2_r <= nt2_r)) ? EDGE_FLOOR : 4'b0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_ctl <= '0;
    end else begin
      f_ctl <= ctl2_r;
    end
    f_vhave  <= vhave_nxt;  f_vmask <= vmask_nxt;  f_vn <= vn_nxt;
    f_valong <= valong_nxt; f_vpos  <= vpos_nxt;
    f_hhave  <= hhave_nxt;  f_hmask <= hmask_nxt;  f_hn <= hn_nxt;
    f_halong <= halong_nxt; f_hpos  <= hpos_nxt;
    f_adx    <= adx2_r;  f_ady <= ady2_r;
    f_sx     <= sx2_r;   f_sy  <= sy2_r;
    f_tx     <= tx2_r;   f_ty  <= ty2_r;
  end

endmodule

@@ sv/sbbc_pick.sv @@
// Cross-axis earliest crossing choice and crossing numerator (two stages).
module sbbc_pick #(
  parameter int W = sbbc_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbbc_pkg::sbbc_ctl_t   f_ctl,
  input  logic                  f_vhave,
  input  logic [3:0]            f_vmask,
  input  logic [W-1:0]          f_vn,
  input  logic signed [2*W+2:0] f_valong,
  input  logic signed [W:0]     f_vpos,
  input  logic                  f_hhave,
  input  logic [3:0]            f_hmask,
  input  logic [W-1:0]          f_hn,
  input  logic signed [2*W+2:0] f_halong,
  input  logic signed [W:0]     f_hpos,
  input  logic [W-1:0]          f_adx,
  input  logic [W-1:0]          f_ady,
  input  logic signed [W-1:0]   f_sx,
  input  logic signed [W-1:0]   f_sy,
  input  logic signed [W-1:0]   f_tx,
  input  logic signed [W-1:0]   f_ty,
  output sbbc_pkg::sbbc_ctl_t   p_ctl,
  output logic                  p_neg,
  output logic [2*W:0]          p_mag,
  output logic [W-1:0]          p_d,
  output logic signed [W:0]     p_pos,
  output logic signed [W-1:0]   p_tx,
  output logic signed [W-1:0]   p_ty
);
  import sbbc_pkg::*;

  localparam int PW = 2 * W + 3;

  // stage 4
  sbbc_ctl_t            ctl4_r;
  logic [2*W-1:0]       cv4_r, ch4_r;
  logic signed [PW-1:0] numv4_r, numh4_r;
  logic                 vhave4_r, hhave4_r;
  logic [3:0]           vmask4_r, hmask4_r;
  logic signed [W:0]    vpos4_r, hpos4_r;
  logic [W-1:0]         adx4_r, ady4_r;
  logic signed [W-1:0]  tx4_r, ty4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else begin
      ctl4_r <= f_ctl;
    end
    cv4_r    <= f_vn * f_ady;
    ch4_r    <= f_hn * f_adx;
    numv4_r  <= f_sy * $signed({1'b0, f_adx}) + f_valong;
    numh4_r  <= f_sx * $signed({1'b0, f_ady}) + f_halong;
    vhave4_r <= f_vhave;  hhave4_r <= f_hhave;
    vmask4_r <= f_vmask;  hmask4_r <= f_hmask;
    vpos4_r  <= f_vpos;   hpos4_r  <= f_hpos;
    adx4_r   <= f_adx;    ady4_r   <= f_ady;
    tx4_r    <= f_tx;     ty4_r    <= f_ty;
  end

  // stage 5
  logic                 selv, selh;
  logic signed [PW-1:0] num, mag_w;
  sbbc_ctl_t            ctl_nxt;

  always_comb begin
    selv = vhave4_r && (!hhave4_r || cv4_r <= ch4_r);
    selh = hhave4_r && (!vhave4_r || ch4_r <= cv4_r);
    num  = selv ? numv4_r : numh4_r;
    mag_w = num[PW-1] ? -num : num;
    ctl_nxt       = ctl4_r;
    ctl_nxt.found = vhave4_r || hhave4_r;
    ctl_nxt.vert  = selv;
    ctl_nxt.mask  = (selv ? vmask4_r : 4'b0000) | (selh ? hmask4_r : 4'b0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl <= '0;
    end else begin
      p_ctl <= ctl_nxt;
    end
    p_neg <= num[PW-1];
    p_mag <= mag_w[2*W:0];
    p_d   <= selv ? adx4_r : ady4_r;
    p_pos <= selv ? vpos4_r : hpos4_r;
    p_tx  <= tx4_r;
    p_ty  <= ty4_r;
  end

endmodule

@@ sv/sbbc_div.sv @@
// Pipelined restoring divider with half-away rounding and result register.
module sbbc_div #(
  parameter int W = sbbc_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbbc_pkg::sbbc_ctl_t p_ctl,
  input  logic                p_neg,
  input  logic [2*W:0]        p_mag,
  input  logic [W-1:0]        p_d,
  input  logic signed [W:0]   p_pos,
  input  logic signed [W-1:0] p_tx,
  input  logic signed [W-1:0] p_ty,
  output logic                out_valid,
  output logic signed [W:0]   out_x,
  output logic signed [W:0]   out_y,
  output logic [3:0]          out_hit_edges
);
  import sbbc_pkg::*;

  localparam int QB = W + 1;

  sbbc_ctl_t           ctl_r  [QB];
  logic [W-1:0]        rem_r  [QB];
  logic [QB-1:0]       q_r    [QB];
  logic [QB-1:0]       low_r  [QB];
  logic [W-1:0]        d_r    [QB];
  logic                neg_r  [QB];
  logic signed [W:0]   pos_r  [QB];
  logic signed [W-1:0] tx_r   [QB];
  logic signed [W-1:0] ty_r   [QB];

  sbbc_ctl_t           ctl_s  [QB];
  logic [W-1:0]        rem_s  [QB];
  logic [QB-1:0]       q_s    [QB];
  logic [QB-1:0]       low_s  [QB];
  logic [W-1:0]        d_s    [QB];
  logic                neg_s  [QB];
  logic signed [W:0]   pos_s  [QB];
  logic signed [W-1:0] tx_s   [QB];
  logic signed [W-1:0] ty_s   [QB];
  logic [W:0]          trial  [QB];
  logic                qbit   [QB];

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      if (s == 0) begin
        ctl_s[s] = p_ctl;  rem_s[s] = p_mag[2*W:QB];  q_s[s] = '0;
        low_s[s] = p_mag[QB-1:0];  d_s[s] = p_d;  neg_s[s] = p_neg;
        pos_s[s] = p_pos;  tx_s[s] = p_tx;  ty_s[s] = p_ty;
      end else begin
        ctl_s[s] = ctl_r[s-1];  rem_s[s] = rem_r[s-1];  q_s[s] = q_r[s-1];
        low_s[s] = low_r[s-1];  d_s[s] = d_r[s-1];  neg_s[s] = neg_r[s-1];
        pos_s[s] = pos_r[s-1];  tx_s[s] = tx_r[s-1];  ty_s[s] = ty_r[s-1];
      end
      trial[s] = {rem_s[s], low_s[s][QB-1]};
      qbit[s]  = trial[s] >= {1'b0, d_s[s]};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QB; s++) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else begin
        ctl_r[s] <= ctl_s[s];
      end
      rem_r[s] <= qbit[s] ? W'(trial[s] - {1'b0, d_s[s]}) : trial[s][W-1:0];
      q_r[s]   <= {q_s[s][QB-2:0], qbit[s]};
      low_r[s] <= {low_s[s][QB-2:0], 1'b0};
      d_r[s]   <= d_s[s];
      neg_r[s] <= neg_s[s];
      pos_r[s] <= pos_s[s];
      tx_r[s]  <= tx_s[s];
      ty_r[s]  <= ty_s[s];
    end
  end

  sbbc_ctl_t         cf;
  logic [QB-1:0]     qf;
  logic signed [W:0] other, x_nxt, y_nxt;
  logic              moved;

  always_comb begin
    cf    = ctl_r[QB-1];
    qf    = q_r[QB-1] + QB'({rem_r[QB-1], 1'b0} >= {1'b0, d_r[QB-1]});
    other = neg_r[QB-1] ? -$signed(qf) : $signed(qf);
    moved = cf.found && !cf.keep;
    if (moved) begin
      x_nxt = cf.vert ? pos_r[QB-1] : other;
      y_nxt = cf.vert ? other : pos_r[QB-1];
    end else begin
      x_nxt = {tx_r[QB-1][W-1], tx_r[QB-1]};
      y_nxt = {ty_r[QB-1][W-1], ty_r[QB-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cf.valid;
    end
    out_x         <= x_nxt;
    out_y         <= y_nxt;
    out_hit_edges <= cf.found ? (cf.mask & ~cf.excl) : 4'b0000;
  end

endmodule

@@ sv/segment_box_border_crossing_top.sv @@
// Top level of the segment/box border crossing block.
// Usage:
//   Raise start with a movement (start, target), a box (corner, width, height,
//   inner/outer kind), an edge mask and keep_target. busy is always low, so a
//   transfer takes place at every clock edge where start is high: one query
//   per cycle, sustained.
//   Each query gives one result. out_valid is high for one cycle, with out_x,
//   out_y and out_hit_edges. Results leave in query order.
//   The divider has COORD_BITS+1 quotient stages, one bit of the rounded
//   crossing coordinate per stage, behind five stages of edge setup, range
//   products, per-axis choice, cross products and final choice.
//   The receiver cannot stall; every result is taken in its strobe cycle.
//   Synchronous active-low reset clears all stage valid bits, so no result
//   appears for queries in flight at reset.
module segment_box_border_crossing_top #(
  parameter int COORD_BITS = sbbc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  input  logic signed [COORD_BITS-1:0] in_box_left,
  input  logic signed [COORD_BITS-1:0] in_box_top,
  input  logic [COORD_BITS-2:0]        in_box_width,
  input  logic [COORD_BITS-2:0]        in_box_height,
  input  logic                         in_box_is_inner,
  input  logic [3:0]                   in_exclude_mask,
  input  logic                         in_keep_target,
  output logic                         out_valid,
  output logic signed [COORD_BITS:0]   out_x,
  output logic signed [COORD_BITS:0]   out_y,
  output logic [3:0]                   out_hit_edges
);
  import sbbc_pkg::*;

  localparam int W = COORD_BITS;

  sbbc_ctl_t              f_ctl, p_ctl;
  logic                   f_vhave, f_hhave, p_neg;
  logic [3:0]             f_vmask, f_hmask;
  logic [W-1:0]           f_vn, f_hn, f_adx, f_ady, p_d;
  logic signed [2*W+2:0]  f_valong, f_halong;
  logic signed [W:0]      f_vpos, f_hpos, p_pos;
  logic signed [W-1:0]    f_sx, f_sy, f_tx, f_ty, p_tx, p_ty;
  logic [2*W:0]           p_mag;

  assign busy = 1'b0;

  sbbc_front #(.W(W)) u_front (
    .clk, .rst_n,
    .in_valid(start && !busy),
    .in_start_x, .in_start_y, .in_target_x, .in_target_y,
    .in_box_left, .in_box_top, .in_box_width, .in_box_height,
    .in_box_is_inner, .in_exclude_mask, .in_keep_target,
    .f_ctl, .f_vhave, .f_vmask, .f_vn, .f_valong, .f_vpos,
    .f_hhave, .f_hmask, .f_hn, .f_halong, .f_hpos,
    .f_adx, .f_ady, .f_sx, .f_sy, .f_tx, .f_ty
  );

  sbbc_pick #(.W(W)) u_pick (
    .clk, .rst_n,
    .f_ctl, .f_vhave, .f_vmask, .f_vn, .f_valong, .f_vpos,
    .f_hhave, .f_hmask, .f_hn, .f_halong, .f_hpos,
    .f_adx, .f_ady, .f_sx, .f_sy, .f_tx, .f_ty,
    .p_ctl, .p_neg, .p_mag, .p_d, .p_pos, .p_tx, .p_ty
  );

  sbbc_div #(.W(W)) u_div (
    .clk, .rst_n,
    .p_ctl, .p_neg, .p_mag, .p_d, .p_pos, .p_tx, .p_ty,
    .out_valid, .out_x, .out_y, .out_hit_edges
  );

endmodule

@@ sv/sbbc_checker.sv @@
// Port-level checks for the border crossing block, bound to the top level.
module sbbc_checker #(
  parameter int COORD_BITS = sbbc_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic signed [COORD_BITS-1:0] in_target_x,
  input logic [3:0]                   in_exclude_mask,
  input logic                         out_valid,
  input logic signed [COORD_BITS:0]   out_x,
  input logic [3:0]                   out_hit_edges
);
  localparam int LAT = COORD_BITS + 7;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching query");

  // with nothing hidden, no reported edge means no crossing, so the target stands
  a_no_hit_keeps_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_edges == 4'd0 && $past(rst_n, LAT) &&
     $past(in_exclude_mask, LAT) == 4'd0) |->
      out_x == $signed($past(in_target_x, LAT)))
    else $error("point moved without visible hit");

  a_mask_respected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_edges & $past(in_exclude_mask, LAT)) == 4'd0)
    else $error("hidden edge reported");

endmodule

bind segment_box_border_crossing_top sbbc_checker #(.COORD_BITS(COORD_BITS)) u_chk (
  .clk, .rst_n, .start, .busy, .in_target_x, .in_exclude_mask,
  .out_valid, .out_x, .out_hit_edges
);

@@ dv/tb_segment_box_border_crossing_top.sv @@
// Testbench: random and directed segment/box crossing queries checked against an exact predictor.
`timescale 1ns / 100ps
module tb_segment_box_border_crossing_top;
  import sbbc_pkg::*;

  localparam int CB = 16;
  localparam int WATCHDOG = 2000;

  typedef struct {
    logic signed [CB-1:0] sx, sy, tx, ty, bl, bt;
    logic [CB-2:0]        bw, bh;
    logic                 inner;
    logic [3:0]           excl;
    logic                 keep;
  } query_t;

  typedef struct {
    logic signed [CB:0] ox, oy;
    logic [3:0]         hits;
  } crossing_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [CB-1:0] in_start_x = 0, in_start_y = 0, in_target_x = 0, in_target_y = 0;
  logic signed [CB-1:0] in_box_left = 0, in_box_top = 0;
  logic [CB-2:0] in_box_width = 0, in_box_height = 0;
  logic in_box_is_inner = 0, in_keep_target = 0;
  logic [3:0] in_exclude_mask = 0;
  logic out_valid;
  logic signed [CB:0] out_x, out_y;
  logic [3:0] out_hit_edges;

  query_t    pending_q[$];
  crossing_t expected_q[$];
  int  fails = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  int  burst_left = 0, gap_left = 0;

  segment_box_border_crossing_top dut (.*);

  always #1 clk = ~clk;

  // n/d rounded half away from zero, d > 0
  function automatic longint round_div(longint n, longint d);
    longint m, q, r;
    m = n < 0 ? -n : n;
    q = m / d;
    r = m % d;
    if (2 * r >= d) q++;
    return n < 0 ? -q : q;
  endfunction

  function automatic void try_edge(input longint n0, input longint d0, input longint so,
                                   input longint dother, input longint lo,
                                   input longint hi, input bit vert, input longint pos,
                                   input logic [3:0] bit_e, inout bit have,
                                   inout longint bn, inout longint bd,
                                   inout logic [3:0] hits, inout longint px,
                                   inout longint py);
    longint n, d, along, other;
    n = d0 < 0 ? -n0 : n0;
    d = d0 < 0 ? -d0 : d0;
    if (!(n > 0 && n <= d)) return;
    along = n * dother;
    if ((lo - so) * d > along) return;
    if (along > (hi - so) * d) return;
    if (!have || n * bd < bn * d) begin
      have = 1; bn = n; bd = d; hits = bit_e;
      other = round_div(so * d + along, d);
      if (vert) begin px = pos; py = other; end
      else begin px = other; py = pos; end
    end else if (n * bd == bn * d) begin
      hits |= bit_e;
    end
  endfunction

  function automatic crossing_t predict_crossing(query_t q);
    crossing_t c;
    longint sx, sy, tx, ty, l, t, r, b, dx, dy, bn, bd, px, py;
    logic [3:0] excl, hits;
    bit sin, tin, react, have;
    sx = q.sx; sy = q.sy; tx = q.tx; ty = q.ty; l = q.bl; t = q.bt;
    r = l + longint'(q.bw);
    b = t + longint'(q.bh);
    excl = q.excl;
    if (sy == t && ty == t) excl |= EDGE_CEIL;
    if (sy == b && ty == b) excl |= EDGE_FLOOR;
    if (sx == l && tx == l) excl |= EDGE_LEFT;
    if (sx == r && tx == r) excl |= EDGE_RIGHT;
    sin = sx >= l && sx <= r && sy >= t && sy <= b;
    tin = tx >= l && tx <= r && ty >= t && ty <= b;
    react = q.inner ? (sin && !tin) : (!sin && tin);
    c.ox = (CB+1)'(tx); c.oy = (CB+1)'(ty); c.hits = 4'b0000;
    if (react) begin
      dx = tx - sx; dy = ty - sy;
      have = 0; bn = 0; bd = 1; hits = 4'b0000; px = tx; py = ty;
      if (dx != 0) begin
        try_edge(l - sx, dx, sy, dy, t, b, 1, l, EDGE_LEFT, have, bn, bd, hits, px, py);
        try_edge(r - sx, dx, sy, dy, t, b, 1, r, EDGE_RIGHT, have, bn, bd, hits, px, py);
      end
      if (dy != 0) begin
        try_edge(t - sy, dy, sx, dx, l, r, 0, t, EDGE_CEIL, have, bn, bd, hits, px, py);
        try_edge(b - sy, dy, sx, dx, l, r, 0, b, EDGE_FLOOR, have, bn, bd, hits, px, py);
      end
      if (have && hits != 0) begin
        if (!q.keep) begin c.ox = (CB+1)'(px); c.oy = (CB+1)'(py); end
        c.hits = hits & ~excl;
      end
    end
    return c;
  endfunction

  function automatic logic signed [CB-1:0] rnd_coord(int span);
    if ($urandom_range(0, 9) == 0) return CB'($urandom);
    return CB'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9);
    q.inner = 1'($urandom);
    q.excl  = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'b0;
    q.keep  = ($urandom_range(0, 4) == 0);
    if (mode == 0) begin
      q.sx = CB'($urandom); q.sy = CB'($urandom);
      q.tx = CB'($urandom); q.ty = CB'($urandom);
      q.bl = CB'($urandom); q.bt = CB'($urandom);
      q.bw = (CB-1)'($urandom); q.bh = (CB-1)'($urandom);
    end else begin
      q.bl = rnd_coord(200); q.bt = rnd_coord(200);
      q.bw = (CB-1)'($urandom_range(0, mode == 1 ? 2 : 300));
      q.bh = (CB-1)'($urandom_range(0, mode == 1 ? 2 : 300));
      q.sx = CB'(q.bl + $signed($urandom_range(0, 700)) - 200);
      q.sy = CB'(q.bt + $signed($urandom_range(0, 700)) - 200);
      q.tx = CB'(q.bl + $signed($urandom_range(0, 700)) - 200);
      q.ty = CB'(q.bt + $signed($urandom_range(0, 700)) - 200);
      if (mode == 2) q.tx = q.sx;
      if (mode == 3) begin q.sy = q.bt; q.ty = q.bt; end
      if (mode == 4) begin q.sx = CB'(q.bl + q.bw); q.tx = q.sx; end
      // reacting pairs: put the start (inner box) or the target (outer box) inside
      if (mode >= 5 && q.bw > 0 && q.bh > 0) begin
        if (q.inner) begin
          q.sx = CB'(q.bl + $urandom_range(0, q.bw));
          q.sy = CB'(q.bt + $urandom_range(0, q.bh));
        end else begin
          q.tx = CB'(q.bl + $urandom_range(0, q.bw));
          q.ty = CB'(q.bt + $urandom_range(0, q.bh));
        end
      end
      if (mode == 9) begin
        // corner-aimed diagonal
        q.sx = CB'(q.bl - 10); q.sy = CB'(q.bt - 10);
        q.tx = CB'(q.bl + 5); q.ty = CB'(q.bt + 5);
        q.inner = 0;
      end
    end
    return q;
  endfunction

  function automatic query_t mk(int sx, int sy, int tx, int ty, int bl, int bt,
                                int bw, int bh, bit inner, logic [3:0] excl, bit keep);
    query_t q;
    q.sx = CB'(sx); q.sy = CB'(sy); q.tx = CB'(tx); q.ty = CB'(ty);
    q.bl = CB'(bl); q.bt = CB'(bt);
    q.bw = (CB-1)'(bw); q.bh = (CB-1)'(bh);
    q.inner = inner; q.excl = excl; q.keep = keep;
    return q;
  endfunction

  initial begin
    pending_q.push_back(mk(-10, 5, 5, 5, 0, 0, 10, 10, 0, 0, 0));
    pending_q.push_back(mk(5, 5, 20, 5, 0, 0, 10, 10, 1, 0, 0));
    pending_q.push_back(mk(5, 5, 5, -7, 0, 0, 10, 10, 1, 0, 0));
    pending_q.push_back(mk(5, 20, 5, 3, 0, 0, 10, 10, 0, 0, 0));
    pending_q.push_back(mk(-5, -5, 5, 5, 0, 0, 10, 10, 0, 0, 0));
    pending_q.push_back(mk(-5, -5, 5, 5, 0, 0, 10, 10, 0, 4'hf, 0));
    pending_q.push_back(mk(-5, -5, 5, 5, 0, 0, 10, 10, 0, 0, 1));
    pending_q.push_back(mk(-5, 0, 5, 0, 0, 0, 10, 10, 0, 0, 0));
    pending_q.push_back(mk(0, -5, 0, 5, 0, 0, 10, 10, 0, 0, 0));
    pending_q.push_back(mk(5, 5, 6, 6, 0, 0, 10, 10, 1, 0, 0));
    pending_q.push_back(mk(-3, 1, 4, 2, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(-3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(0, 0, 3, 2, 0, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(1, 1, 4, 2, 0, 0, 2, 2, 1, 0, 0));
    pending_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 1, 0, 0));
    pending_q.push_back(mk(32767, 32767, -32768, -32768, 0, 0, 32767, 32767, 0, 0, 0));
    pending_q.push_back(mk(-32768, 32767, 32767, -32768, -100, -100, 200, 200, 0, 4'h5, 0));
    pending_q.push_back(mk(0, 0, 32767, 1, -32768, -32768, 32767, 32767, 1, 0, 0));
    pending_q.push_back(mk(-1, -32768, 1, 32767, 0, 0, 0, 32767, 0, 0, 0));
    pending_q.push_back(mk(3, 3, 9, 9, 0, 0, 10, 10, 1, 0, 0));
    repeat (1200) pending_q.push_back(rnd_query());
    stim_done = 1;
  end

  // driver: bursts with gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_q.push_back(predict_crossing(pending_q.pop_front()));
      if (start && busy) begin
        // hold current item
      end else if (pending_q.size() > 0 && gap_left == 0) begin
        query_t q;
        q = pending_q[0];
        start <= 1'b1;
        in_start_x <= q.sx; in_start_y <= q.sy;
        in_target_x <= q.tx; in_target_y <= q.ty;
        in_box_left <= q.bl; in_box_top <= q.bt;
        in_box_width <= q.bw; in_box_height <= q.bh;
        in_box_is_inner <= q.inner; in_exclude_mask <= q.excl;
        in_keep_target <= q.keep;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d hits=%h", out_x, out_y, out_hit_edges);
        fails++;
      end else begin
        crossing_t e;
        e = expected_q.pop_front();
        if (out_x !== e.ox) begin $error("out_x exp %0d got %0d", e.ox, out_x); fails++; end
        if (out_y !== e.oy) begin $error("out_y exp %0d got %0d", e.oy, out_y); fails++; end
        if (out_hit_edges !== e.hits) begin
          $error("out_hit_edges exp %h got %h", e.hits, out_hit_edges);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    wait (stim_done && pending_q.size() == 0);
    @(posedge clk);
    wait (expected_q.size() == 0);
    repeat (2 * CB + 12) @(posedge clk);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
